>>> rtl/socc_pkg.sv
package socc_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_INFLATION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SNAP = 2'd1;
	localparam logic [CFG_W-1:0] SNAP_RESET = 16'd256;

	localparam int STEP_BITS = 5;
	localparam logic [STEP_BITS-1:0] BEGIN_LAST = 5'd5;
	localparam logic [STEP_BITS-1:0] OBST_LAST = 5'd16;

	typedef enum logic [1:0] {
		OP_BEGIN       = 2'd0,
		OP_BEGIN_EMPTY = 2'd1,
		OP_OBST        = 2'd2,
		OP_LAST        = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		SRC_R, SRC_SNAP, SRC_DAX, SRC_DAY, SRC_DBX, SRC_DBY, SRC_DX, SRC_DY,
		SRC_RL, SRC_RH, SRC_LL, SRC_LH, SRC_CL, SRC_CH
	} src_t;

	typedef enum logic [1:0] {ACC_NONE, ACC_LOAD, ACC_ADD, ACC_SUB} acc_mode_t;

	typedef enum logic [1:0] {SH_0, SH_1, SH_2} shift_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_R2, DST_DOT, DST_DS, DST_DE, DST_CROSS, DST_RHS, DST_C2,
		DST_DSN, DST_LEN2
	} dst_t;

	typedef struct packed {
		acc_mode_t mode;
		shift_t    sh;
		dst_t      dst;
	} mac_ctl_t;

	typedef struct packed {
		src_t     a;
		src_t     b;
		mac_ctl_t ctl;
	} uop_t;

	localparam mac_ctl_t MAC_IDLE = '{mode: ACC_NONE, sh: SH_0, dst: DST_NONE};

	function automatic uop_t mk(input src_t a, input src_t b, input acc_mode_t m,
			input shift_t s, input dst_t d);
		uop_t u;
		u.a = a;
		u.b = b;
		u.ctl.mode = m;
		u.ctl.sh = s;
		u.ctl.dst = d;
		return u;
	endfunction

	// partial product schedule, one multiply per step
	function automatic uop_t uop_at(input logic is_begin, input logic [STEP_BITS-1:0] step);
		uop_t u;
		u = mk(SRC_R, SRC_R, ACC_NONE, SH_0, DST_NONE);
		if (is_begin) begin
			unique case (step)
				5'd0: u = mk(SRC_SNAP, SRC_SNAP, ACC_LOAD, SH_0, DST_R2);
				5'd1: u = mk(SRC_DAX, SRC_DAX, ACC_LOAD, SH_0, DST_NONE);
				5'd2: u = mk(SRC_DAY, SRC_DAY, ACC_ADD, SH_0, DST_DSN);
				5'd4: u = mk(SRC_DX, SRC_DX, ACC_LOAD, SH_0, DST_NONE);
				5'd5: u = mk(SRC_DY, SRC_DY, ACC_ADD, SH_0, DST_LEN2);
				default: u = mk(SRC_R, SRC_R, ACC_NONE, SH_0, DST_NONE);
			endcase
		end else begin
			unique case (step)
				5'd0:  u = mk(SRC_R, SRC_R, ACC_LOAD, SH_0, DST_R2);
				5'd1:  u = mk(SRC_DAX, SRC_DX, ACC_LOAD, SH_0, DST_NONE);
				5'd2:  u = mk(SRC_DAY, SRC_DY, ACC_ADD, SH_0, DST_DOT);
				5'd3:  u = mk(SRC_DAX, SRC_DAX, ACC_LOAD, SH_0, DST_NONE);
				5'd4:  u = mk(SRC_DAY, SRC_DAY, ACC_ADD, SH_0, DST_DS);
				5'd5:  u = mk(SRC_DBX, SRC_DBX, ACC_LOAD, SH_0, DST_NONE);
				5'd6:  u = mk(SRC_DBY, SRC_DBY, ACC_ADD, SH_0, DST_DE);
				5'd7:  u = mk(SRC_DX, SRC_DAY, ACC_LOAD, SH_0, DST_NONE);
				5'd8:  u = mk(SRC_DY, SRC_DAX, ACC_SUB, SH_0, DST_CROSS);
				5'd9:  u = mk(SRC_RL, SRC_LL, ACC_LOAD, SH_0, DST_NONE);
				5'd10: u = mk(SRC_RL, SRC_LH, ACC_ADD, SH_1, DST_NONE);
				5'd11: u = mk(SRC_RH, SRC_LL, ACC_ADD, SH_1, DST_NONE);
				5'd12: u = mk(SRC_RH, SRC_LH, ACC_ADD, SH_2, DST_RHS);
				5'd13: u = mk(SRC_CL, SRC_CL, ACC_LOAD, SH_0, DST_NONE);
				5'd14: u = mk(SRC_CL, SRC_CH, ACC_ADD, SH_1, DST_NONE);
				5'd15: u = mk(SRC_CL, SRC_CH, ACC_ADD, SH_1, DST_NONE);
				5'd16: u = mk(SRC_CH, SRC_CH, ACC_ADD, SH_2, DST_C2);
				default: u = mk(SRC_R, SRC_R, ACC_NONE, SH_0, DST_NONE);
			endcase
		end
		return u;
	endfunction

endpackage

>>> rtl/socc_mac.sv
module socc_mac #(
	parameter int SW = 26,
	parameter int MW = 25,
	parameter int AW = 104
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic signed [SW-1:0]    a,
	input  logic signed [SW-1:0]    b,
	input  socc_pkg::mac_ctl_t      ctl,
	output logic signed [AW-1:0]    acc,
	output socc_pkg::dst_t          dest
);
	import socc_pkg::*;

	logic signed [2*SW-1:0] prod_s1;
	mac_ctl_t               ctl_s1;
	logic signed [AW-1:0]   acc_q;
	logic signed [AW-1:0]   ext;
	logic signed [AW-1:0]   term;
	logic signed [AW-1:0]   base;
	logic signed [AW-1:0]   sum;

	always_ff @(posedge clk) begin
		prod_s1 <= a * b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= MAC_IDLE;
		end else begin
			ctl_s1 <= ctl;
		end
	end

	always_comb begin
		ext = AW'(prod_s1);
		unique case (ctl_s1.sh)
			SH_0: term = ext;
			SH_1: term = ext <<< MW;
			SH_2: term = ext <<< (2 * MW);
			default: term = ext;
		endcase
		base = (ctl_s1.mode == ACC_LOAD) ? '0 : acc_q;
		sum = (ctl_s1.mode == ACC_SUB) ? base - term : base + term;
	end

	always_ff @(posedge clk) begin
		if (ctl_s1.mode != ACC_NONE) begin
			acc_q <= sum;
		end
	end

	assign acc = sum;
	assign dest = (ctl_s1.mode != ACC_NONE) ? ctl_s1.dst : DST_NONE;

endmodule

>>> rtl/segment_obstacle_clearance_check.sv
// Segment obstacle clearance check. A begin item fixes the segment (start snaps to the
// previous target when it lies strictly within snap_radius of the pose) and clears the hit
// flag; each obstacle item tests exactly, in integer arithmetic, whether the segment's
// closest point lies strictly inside the obstacle circle grown by obstacle_inflation. The
// flag is ORed over the list and needs_replan is given on the last obstacle, or 0 on a
// begin with an empty list. One shared signed multiplier with a wide accumulator does all
// the work, one partial product per cycle: a begin item takes 5 products and one idle step
// while the chosen start settles, an obstacle 17 products, with the squared cross product
// and radius-times-length terms split into halves; a new item is taken only in idle.
// An item that gives a result passes through the push state into the output register,
// where it waits for the sink without holding up later items that give none.
module segment_obstacle_clearance_check #(
	parameter int COORD_BITS = 24,
	parameter int RADIUS_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [socc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [socc_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        op,
	input  logic signed [COORD_BITS-1:0]      robot_x,
	input  logic signed [COORD_BITS-1:0]      robot_y,
	input  logic signed [COORD_BITS-1:0]      prev_target_x,
	input  logic signed [COORD_BITS-1:0]      prev_target_y,
	input  logic signed [COORD_BITS-1:0]      dest_x,
	input  logic signed [COORD_BITS-1:0]      dest_y,
	input  logic signed [COORD_BITS-1:0]      obs_x,
	input  logic signed [COORD_BITS-1:0]      obs_y,
	input  logic [RADIUS_BITS-1:0]            obs_radius,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              needs_replan
);
	import socc_pkg::*;

	localparam int DIFW = COORD_BITS + 1;
	localparam int RW = ((RADIUS_BITS > CFG_W) ? RADIUS_BITS : CFG_W) + 1;
	localparam int MW = (DIFW > RW) ? DIFW : RW;
	localparam int SW = MW + 1;
	localparam int AW = 4 * MW + 4;
	localparam int R2W = 2 * MW;
	localparam int LW = 2 * COORD_BITS + 2;
	localparam int DOTW = 2 * COORD_BITS + 3;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_RUN   = 5'b00010,
		ST_DRAIN = 5'b00100,
		ST_EVAL  = 5'b01000,
		ST_PUSH  = 5'b10000
	} state_t;

	state_t                 state_q;
	logic [STEP_BITS-1:0]   step_q;
	op_t                    op_q;
	op_t                    in_op;
	logic [CFG_W-1:0]       inflation_q;
	logic [CFG_W-1:0]       snap_q;

	logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;
	logic signed [COORD_BITS-1:0] px_q, py_q, rx_q, ry_q;
	logic signed [DIFW-1:0]       seg_dx_q, seg_dy_q;
	logic signed [DIFW-1:0]       da_x_q, da_y_q, db_x_q, db_y_q, dc_x_q, dc_y_q;
	logic [LW-1:0]                len2_q;
	logic [RW-1:0]                r_q;
	logic [R2W-1:0]               r2_q;
	logic signed [DOTW-1:0]       dot_q;
	logic signed [DOTW-1:0]       cross_q;
	logic [AW-1:0]                rhs_q;
	logic                         ds_lt_q, de_lt_q, c2_lt_q;
	logic                         hit_seen_q;
	logic                         out_valid_q;
	logic                         needs_replan_q;

	logic                   in_fire;
	logic                   push_fire;
	logic                   is_begin;
	logic                   run_last;
	uop_t                   uop;
	mac_ctl_t               mac_ctl;
	logic signed [SW-1:0]   opa, opb;
	logic signed [AW-1:0]   mac_acc;
	dst_t                   mac_dest;
	logic                   r2_cmp;
	logic                   snap_lt;
	logic [DOTW-1:0]        cross_mag;
	logic [MW-1:0]          cl, ch, ll, lh, rl, rh;
	logic                   dot_le0, dot_ge, zero_len, hit;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign in_op = op_t'(op);
	assign push_fire = (state_q == ST_PUSH) && (!out_valid_q || out_ready);
	assign is_begin = (op_q == OP_BEGIN) || (op_q == OP_BEGIN_EMPTY);
	assign run_last = (step_q == (is_begin ? BEGIN_LAST : OBST_LAST));

	assign uop = uop_at(is_begin, step_q);
	assign mac_ctl = (state_q == ST_RUN) ? uop.ctl : MAC_IDLE;

	// operand halves for the wide products
	assign cross_mag = cross_q[DOTW-1] ? $unsigned(-cross_q) : $unsigned(cross_q);
	assign cl = cross_mag[MW-1:0];
	assign ch = MW'(cross_mag >> MW);
	assign ll = len2_q[MW-1:0];
	assign lh = MW'(len2_q >> MW);
	assign rl = r2_q[MW-1:0];
	assign rh = r2_q[R2W-1:MW];

	always_comb begin
		unique case (uop.a)
			SRC_R:    opa = SW'(r_q);
			SRC_SNAP: opa = SW'(snap_q);
			SRC_DAX:  opa = SW'(da_x_q);
			SRC_DAY:  opa = SW'(da_y_q);
			SRC_DBX:  opa = SW'(db_x_q);
			SRC_DBY:  opa = SW'(db_y_q);
			SRC_DX:   opa = SW'(seg_dx_q);
			SRC_DY:   opa = SW'(seg_dy_q);
			SRC_RL:   opa = SW'(rl);
			SRC_RH:   opa = SW'(rh);
			SRC_LL:   opa = SW'(ll);
			SRC_LH:   opa = SW'(lh);
			SRC_CL:   opa = SW'(cl);
			SRC_CH:   opa = SW'(ch);
			default:  opa = '0;
		endcase
		unique case (uop.b)
			SRC_R:    opb = SW'(r_q);
			SRC_SNAP: opb = SW'(snap_q);
			SRC_DAX:  opb = SW'(da_x_q);
			SRC_DAY:  opb = SW'(da_y_q);
			SRC_DBX:  opb = SW'(db_x_q);
			SRC_DBY:  opb = SW'(db_y_q);
			SRC_DX:   opb = SW'(seg_dx_q);
			SRC_DY:   opb = SW'(seg_dy_q);
			SRC_RL:   opb = SW'(rl);
			SRC_RH:   opb = SW'(rh);
			SRC_LL:   opb = SW'(ll);
			SRC_LH:   opb = SW'(lh);
			SRC_CL:   opb = SW'(cl);
			SRC_CH:   opb = SW'(ch);
			default:  opb = '0;
		endcase
	end

	socc_mac #(
		.SW(SW),
		.MW(MW),
		.AW(AW)
	) u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.a(opa),
		.b(opb),
		.ctl(mac_ctl),
		.acc(mac_acc),
		.dest(mac_dest)
	);

	assign r2_cmp = $unsigned(mac_acc) < AW'(r2_q);
	assign snap_lt = r2_cmp;

	// closest point: before start, past end, or on the segment interior
	assign zero_len = (len2_q == '0);
	assign dot_le0 = dot_q[DOTW-1] || (dot_q == '0);
	assign dot_ge = !dot_q[DOTW-1] && ($unsigned(dot_q) >= {1'b0, len2_q});
	always_comb begin
		priority if (zero_len || dot_le0) begin
			hit = ds_lt_q;
		end else if (dot_ge) begin
			hit = de_lt_q;
		end else begin
			hit = c2_lt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflation_q <= '0;
			snap_q <= SNAP_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_INFLATION: inflation_q <= cfg_data;
				CFG_SNAP:      snap_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			op_q <= OP_BEGIN;
			hit_seen_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						op_q <= in_op;
						step_q <= '0;
						state_q <= ST_RUN;
						if (in_op == OP_BEGIN || in_op == OP_BEGIN_EMPTY) begin
							hit_seen_q <= 1'b0;
						end
					end
				end
				ST_RUN: begin
					if (run_last) begin
						state_q <= ST_DRAIN;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (!is_begin && hit) begin
						hit_seen_q <= 1'b1;
					end
					if (op_q == OP_BEGIN_EMPTY || op_q == OP_LAST) begin
						state_q <= ST_PUSH;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_PUSH: begin
					if (push_fire) begin
						hit_seen_q <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// segment state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q <= '0;
			start_y_q <= '0;
			end_x_q <= '0;
			end_y_q <= '0;
			seg_dx_q <= '0;
			seg_dy_q <= '0;
			len2_q <= '0;
		end else begin
			if (in_fire && (in_op == OP_BEGIN || in_op == OP_BEGIN_EMPTY)) begin
				end_x_q <= dest_x;
				end_y_q <= dest_y;
			end
			if (mac_dest == DST_DSN) begin
				start_x_q <= snap_lt ? px_q : rx_q;
				start_y_q <= snap_lt ? py_q : ry_q;
				seg_dx_q <= snap_lt ? dc_x_q : db_x_q;
				seg_dy_q <= snap_lt ? dc_y_q : db_y_q;
			end
			if (mac_dest == DST_LEN2) begin
				len2_q <= LW'($unsigned(mac_acc));
			end
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (in_op == OP_BEGIN || in_op == OP_BEGIN_EMPTY) begin
				px_q <= prev_target_x;
				py_q <= prev_target_y;
				rx_q <= robot_x;
				ry_q <= robot_y;
				da_x_q <= DIFW'(prev_target_x) - DIFW'(robot_x);
				da_y_q <= DIFW'(prev_target_y) - DIFW'(robot_y);
				db_x_q <= DIFW'(dest_x) - DIFW'(robot_x);
				db_y_q <= DIFW'(dest_y) - DIFW'(robot_y);
				dc_x_q <= DIFW'(dest_x) - DIFW'(prev_target_x);
				dc_y_q <= DIFW'(dest_y) - DIFW'(prev_target_y);
			end else begin
				da_x_q <= DIFW'(obs_x) - DIFW'(start_x_q);
				da_y_q <= DIFW'(obs_y) - DIFW'(start_y_q);
				db_x_q <= DIFW'(obs_x) - DIFW'(end_x_q);
				db_y_q <= DIFW'(obs_y) - DIFW'(end_y_q);
				r_q <= RW'(obs_radius) + RW'(inflation_q);
			end
		end
	end

	// accumulator results
	always_ff @(posedge clk) begin
		unique case (mac_dest)
			DST_R2:    r2_q <= R2W'($unsigned(mac_acc));
			DST_DOT:   dot_q <= DOTW'(mac_acc);
			DST_DS:    ds_lt_q <= r2_cmp;
			DST_DE:    de_lt_q <= r2_cmp;
			DST_CROSS: cross_q <= DOTW'(mac_acc);
			DST_RHS:   rhs_q <= $unsigned(mac_acc);
			DST_C2:    c2_lt_q <= $unsigned(mac_acc) < rhs_q;
			default: begin
			end
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (push_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push_fire) begin
			needs_replan_q <= hit_seen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign needs_replan = needs_replan_q;

	a_out_from_push: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_PUSH))
		else $error("result appeared outside the push state");

	a_final_product_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_dest == DST_C2 || mac_dest == DST_LEN2) |-> (state_q == ST_DRAIN))
		else $error("final product accumulated out of sequence");

	a_begin_clears_hits: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && (in_op == OP_BEGIN || in_op == OP_BEGIN_EMPTY)) |=> !hit_seen_q)
		else $error("hit flag not cleared by begin transfer");

endmodule
